// ===== hw/rtl/sbt_pkg.sv =====
// Shared types, constants and the per-pass lexer function of the
// s-expression byte tokenizer. Depends on nothing; used by every module.

package sbt_pkg;

    localparam int MAX_RES = 3;    // results one source byte may cause
    localparam int PASSES  = 4;    // most dispatch passes spent on one byte
    localparam int VALUE_W = 64;   // integer token width
    localparam int DATA_W  = 8 + VALUE_W;

    localparam logic [7:0] ESC_BYTE = 8'h1B;   // "\e"

    typedef enum logic [10:0] {
        M_IDLE    = 11'b000_0000_0001,
        M_COMMENT = 11'b000_0000_0010,
        M_STRING  = 11'b000_0000_0100,
        M_ESC     = 11'b000_0000_1000,
        M_OCT     = 11'b000_0001_0000,
        M_HEX1    = 11'b000_0010_0000,
        M_HEX     = 11'b000_0100_0000,
        M_IDENT   = 11'b000_1000_0000,
        M_SIGN    = 11'b001_0000_0000,
        M_ZERO    = 11'b010_0000_0000,
        M_NUM     = 11'b100_0000_0000
    } lex_mode_t;

    typedef enum logic [1:0] {
        R_BIN = 2'd0,
        R_OCT = 2'd1,
        R_DEC = 2'd2,
        R_HEX = 2'd3
    } radix_t;

    typedef enum logic [3:0] {
        K_LPAREN  = 4'd0,
        K_RPAREN  = 4'd1,
        K_LBRACK  = 4'd2,
        K_RBRACK  = 4'd3,
        K_DOT     = 4'd4,
        K_STRBYTE = 4'd5,
        K_STREND  = 4'd6,
        K_IDBYTE  = 4'd7,
        K_IDEND   = 4'd8,
        K_INT     = 4'd9,
        K_EOF     = 4'd10,
        K_BADNUM  = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_START = 2'd1,
        ACC_MADD  = 2'd2
    } acc_op_t;

    typedef struct packed {
        lex_mode_t  mode;
        radix_t     radix;
        logic       negative;
        logic [7:0] pending_sign;
        logic [1:0] esc_count;
        logic [7:0] esc_value;
    } lex_state_t;

    typedef struct packed {
        lex_state_t st;
        logic       again;
        logic       emit;
        kind_t      kind;
        logic [7:0] data;
        acc_op_t    acc_op;
    } pass_t;

    // All results of one source byte, drained one beat at a time.
    typedef struct packed {
        logic [1:0]                  n;
        kind_t [MAX_RES-1:0]         kinds;
        logic [MAX_RES-1:0][7:0]     datas;
        logic [VALUE_W-1:0]          value;
    } res_group_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_delim(logic [7:0] c, logic end_mark);
        return end_mark || is_space(c) ||
               (c inside {8'h22, 8'h28, 8'h29, 8'h23, 8'h5B, 8'h5D});
    endfunction

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, c[3:0]};
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // One dispatch of the lexer on the current byte.
    function automatic pass_t lex_pass(lex_state_t s, logic [7:0] c, logic end_mark);
        pass_t      p;
        logic [4:0] hx;
        logic       dig_ok;
        logic [7:0] ov;
        logic [1:0] oc;
        p        = '{st: s, again: 1'b0, emit: 1'b0, kind: K_EOF, data: 8'd0,
                     acc_op: ACC_HOLD};
        hx       = hex_digit(c);
        ov       = {s.esc_value[4:0], 3'b000} + {5'd0, c[2:0]};
        oc       = s.esc_count + 2'd1;
        case (s.radix)
            R_BIN:   dig_ok = hx[4] && (hx[3:0] < 4'd2);
            R_OCT:   dig_ok = hx[4] && (hx[3:0] < 4'd8);
            R_DEC:   dig_ok = hx[4] && (hx[3:0] < 4'd10);
            default: dig_ok = hx[4];
        endcase
        case (s.mode)
            M_IDLE:
            begin
                if (end_mark)
                begin
                    p.emit = 1'b1;
                    p.kind = K_EOF;
                end
                else if (!is_space(c))
                begin
                    case (c)
                        8'h23: p.st.mode = M_COMMENT;
                        8'h28: begin p.emit = 1'b1; p.kind = K_LPAREN; end
                        8'h29: begin p.emit = 1'b1; p.kind = K_RPAREN; end
                        8'h5B: begin p.emit = 1'b1; p.kind = K_LBRACK; end
                        8'h5D: begin p.emit = 1'b1; p.kind = K_RBRACK; end
                        8'h2E: begin p.emit = 1'b1; p.kind = K_DOT; end
                        8'h22: p.st.mode = M_STRING;
                        8'h2B, 8'h2D:
                        begin
                            p.st.pending_sign = c;
                            p.st.mode         = M_SIGN;
                        end
                        default:
                        begin
                            if (c inside {[8'h30:8'h39]})
                            begin
                                p.st.negative = 1'b0;
                                p.st.radix    = R_DEC;
                                p.acc_op      = ACC_START;
                                p.st.mode     = (c == 8'h30) ? M_ZERO : M_NUM;
                            end
                            else
                            begin
                                p.emit    = 1'b1;
                                p.kind    = K_IDBYTE;
                                p.data    = c;
                                p.st.mode = M_IDENT;
                            end
                        end
                    endcase
                end
            end
            M_COMMENT:
            begin
                if (end_mark)
                begin
                    p.st.mode = M_IDLE;
                    p.again   = 1'b1;
                end
                else if (c == 8'h0A)
                    p.st.mode = M_IDLE;
            end
            M_STRING:
            begin
                if (end_mark || c == 8'h22)
                begin
                    p.emit    = 1'b1;
                    p.kind    = K_STREND;
                    p.st.mode = M_IDLE;
                    p.again   = end_mark;
                end
                else if (c == 8'h5C)
                    p.st.mode = M_ESC;
                else
                begin
                    p.emit = 1'b1;
                    p.kind = K_STRBYTE;
                    p.data = c;
                end
            end
            M_ESC:
            begin
                p.st.mode = M_STRING;
                if (end_mark)
                    p.again = 1'b1;
                else
                begin
                    p.kind = K_STRBYTE;
                    case (c)
                        8'h61: begin p.emit = 1'b1; p.data = 8'h07; end
                        8'h62: begin p.emit = 1'b1; p.data = 8'h08; end
                        8'h65: begin p.emit = 1'b1; p.data = ESC_BYTE; end
                        8'h66: begin p.emit = 1'b1; p.data = 8'h0C; end
                        8'h6E: begin p.emit = 1'b1; p.data = 8'h0A; end
                        8'h72: begin p.emit = 1'b1; p.data = 8'h0D; end
                        8'h74: begin p.emit = 1'b1; p.data = 8'h09; end
                        8'h76: begin p.emit = 1'b1; p.data = 8'h0B; end
                        8'h78: p.st.mode = M_HEX1;
                        8'h75, 8'h55: p.st.mode = M_STRING;
                        default:
                        begin
                            if (c inside {[8'h30:8'h37]})
                            begin
                                p.st.esc_value = {5'd0, c[2:0]};
                                p.st.esc_count = 2'd1;
                                p.st.mode      = M_OCT;
                            end
                            else
                            begin
                                p.emit = 1'b1;
                                p.data = c;
                            end
                        end
                    endcase
                end
            end
            M_OCT:
            begin
                p.kind = K_STRBYTE;
                if (!end_mark && (c inside {[8'h30:8'h37]}))
                begin
                    p.st.esc_value = ov;
                    p.st.esc_count = oc;
                    if (oc == 2'd3)
                    begin
                        p.emit         = 1'b1;
                        p.data         = ov;
                        p.st.esc_count = 2'd0;
                        p.st.mode      = M_STRING;
                    end
                end
                else
                begin
                    p.emit         = 1'b1;
                    p.data         = s.esc_value;
                    p.st.esc_count = 2'd0;
                    p.st.mode      = M_STRING;
                    p.again        = 1'b1;
                end
            end
            M_HEX1:
            begin
                if (!end_mark && hx[4])
                begin
                    p.st.esc_value = {4'd0, hx[3:0]};
                    p.st.mode      = M_HEX;
                end
                else
                begin
                    p.emit    = 1'b1;
                    p.kind    = K_STRBYTE;
                    p.data    = 8'h78;
                    p.st.mode = M_STRING;
                    p.again   = 1'b1;
                end
            end
            M_HEX:
            begin
                if (!end_mark && hx[4])
                    p.st.esc_value = {s.esc_value[3:0], hx[3:0]};
                else
                begin
                    p.emit    = 1'b1;
                    p.kind    = K_STRBYTE;
                    p.data    = s.esc_value;
                    p.st.mode = M_STRING;
                    p.again   = 1'b1;
                end
            end
            M_IDENT:
            begin
                p.emit = 1'b1;
                if (is_delim(c, end_mark))
                begin
                    p.kind    = K_IDEND;
                    p.st.mode = M_IDLE;
                    p.again   = 1'b1;
                end
                else
                begin
                    p.kind = K_IDBYTE;
                    p.data = c;
                end
            end
            M_SIGN:
            begin
                if (!end_mark && (c inside {[8'h30:8'h39]}))
                begin
                    p.st.negative = (s.pending_sign == 8'h2D);
                    p.st.radix    = R_DEC;
                    p.acc_op      = ACC_START;
                    p.st.mode     = (c == 8'h30) ? M_ZERO : M_NUM;
                end
                else
                begin
                    p.emit    = 1'b1;
                    p.kind    = K_IDBYTE;
                    p.data    = s.pending_sign;
                    p.st.mode = M_IDENT;
                    p.again   = 1'b1;
                end
            end
            M_ZERO:
            begin
                p.st.mode = M_NUM;
                if (!end_mark && (c inside {8'h62, 8'h42}))
                    p.st.radix = R_BIN;
                else if (!end_mark && (c inside {8'h6F, 8'h4F}))
                    p.st.radix = R_OCT;
                else if (!end_mark && (c inside {8'h64, 8'h44}))
                    p.st.radix = R_DEC;
                else if (!end_mark && (c inside {8'h78, 8'h58}))
                    p.st.radix = R_HEX;
                else
                    p.again = 1'b1;
            end
            M_NUM:
            begin
                if (!end_mark && dig_ok)
                    p.acc_op = ACC_MADD;
                else
                begin
                    p.emit    = 1'b1;
                    p.st.mode = M_IDLE;
                    if (is_delim(c, end_mark))
                    begin
                        p.kind  = K_INT;
                        p.again = 1'b1;
                    end
                    else
                        p.kind = K_BADNUM;
                end
            end
            default:
            begin
                p.st.mode = M_IDLE;
                p.again   = 1'b1;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/sbt_lex_core.sv =====
// Lexer state registers and the chained dispatch passes for one byte.
// Depends on sbt_pkg; feeds a result group to sbt_result_fifo for each byte that causes results.

module sbt_lex_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [7:0]          item_byte,
    input  logic                item_end,
    output logic                grp_push,
    output sbt_pkg::res_group_t grp
);

    sbt_pkg::lex_state_t          st_reg;
    sbt_pkg::lex_state_t          st_next;
    logic [sbt_pkg::VALUE_W-1:0]  acc_reg;
    logic [sbt_pkg::VALUE_W-1:0]  acc_next;

    sbt_pkg::lex_state_t st_w;
    sbt_pkg::pass_t      pr;
    sbt_pkg::acc_op_t    op;
    logic                active;
    logic [1:0]          cnt;

    // Re-dispatch the byte while a pass hands it on; at most PASSES times.
    always_comb
    begin
        st_w   = st_reg;
        pr     = '0;
        op     = sbt_pkg::ACC_HOLD;
        active = 1'b1;
        cnt    = 2'd0;
        for (int i = 0; i < sbt_pkg::MAX_RES; i++)
        begin
            grp.kinds[i] = sbt_pkg::K_EOF;
            grp.datas[i] = 8'd0;
        end
        for (int p = 0; p < sbt_pkg::PASSES; p++)
        begin
            if (active)
            begin
                pr   = sbt_pkg::lex_pass(st_w, item_byte, item_end);
                st_w = pr.st;
                if (pr.emit && cnt != 2'd3)
                begin
                    grp.kinds[cnt] = pr.kind;
                    grp.datas[cnt] = pr.data;
                    cnt            = cnt + 2'd1;
                end
                if (pr.acc_op != sbt_pkg::ACC_HOLD)
                    op = pr.acc_op;
                active = pr.again;
            end
        end
        grp.n     = cnt;
        // an integer token always closes the number held before this byte
        grp.value = st_reg.negative ? (64'd0 - acc_reg) : acc_reg;
        grp_push  = item_valid && (cnt != 2'd0);
        st_next   = item_valid ? st_w : st_reg;
    end

    logic [4:0] byte_hex;
    logic [3:0] digit;
    assign byte_hex = sbt_pkg::hex_digit(item_byte);
    assign digit    = byte_hex[3:0];

    always_comb
    begin
        acc_next = acc_reg;
        if (item_valid)
        begin
            case (op)
                sbt_pkg::ACC_START: acc_next = {60'd0, item_byte[3:0]};
                sbt_pkg::ACC_MADD:
                begin
                    case (st_reg.radix)
                        sbt_pkg::R_BIN: acc_next = {acc_reg[62:0], 1'b0} + {60'd0, digit};
                        sbt_pkg::R_OCT: acc_next = {acc_reg[60:0], 3'b0} + {60'd0, digit};
                        sbt_pkg::R_DEC: acc_next = {acc_reg[60:0], 3'b0}
                                                 + {acc_reg[62:0], 1'b0} + {60'd0, digit};
                        default:        acc_next = {acc_reg[59:0], 4'b0} + {60'd0, digit};
                    endcase
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '{mode: sbt_pkg::M_IDLE, radix: sbt_pkg::R_DEC, negative: 1'b0,
                         pending_sign: 8'd0, esc_count: 2'd0, esc_value: 8'd0};
            acc_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/sbt_result_fifo.sv =====
// Result-group queue and the output port that drains each group beat by beat.
// Depends on sbt_pkg; written by sbt_lex_core.

module sbt_result_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  sbt_pkg::res_group_t           grp,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbt_pkg::DATA_W-1:0]    m_tdata,   // out_byte[7:0], int_value[71:8]
    output logic [3:0]                    m_tuser,   // kind[3:0]
    output logic                          m_tlast,
    output logic [$clog2(DEPTH+1)-1:0]    level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);

    sbt_pkg::res_group_t mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [1:0]          sub_reg, sub_next;
    sbt_pkg::res_group_t head;
    sbt_pkg::kind_t      head_kind;
    logic                pop;

    assign head      = mem[rd_ptr_reg];
    assign head_kind = head.kinds[sub_reg];
    assign m_tvalid  = (level_reg != '0);
    assign m_tuser   = head_kind;
    assign m_tdata   = {(head_kind == sbt_pkg::K_INT) ? head.value : 64'd0,
                        head.datas[sub_reg]};
    assign m_tlast   = (sub_reg == head.n - 2'd1);
    assign pop       = m_tvalid && m_tready && m_tlast;
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            sub_next    = 2'd0;
        end
        else if (m_tvalid && m_tready)
            sub_next = sub_reg + 2'd1;
        level_next = level_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

// ===== hw/rtl/sexpr_byte_tokenizer.sv =====
// Top level of the s-expression byte tokenizer: input register, lexer core,
// result queue and checks. Depends on sbt_pkg, sbt_lex_core, sbt_result_fifo.

// The tokenizer takes one source byte per beat on the slave side (s_tlast
// high marks the end of the stream, and the byte is then ignored) and
// returns tokens on the master side, one token per beat: the kind in
// m_tuser, the string or identifier byte in m_tdata[7:0], and the two's
// complement integer value in m_tdata[71:8]. m_tlast marks the final token
// caused by one source byte; a byte causes zero to three tokens. A byte is
// taken every cycle as long as the result queue has room; the first token
// of a byte passes from the input register through the lexer pass logic
// into the result queue before it appears. The output port moves one token
// per cycle while m_tready is high, so bytes that each cause several tokens
// slow the input, and FIFO_DEPTH result groups absorb bursts while the
// consumer stalls. No clearing pass is needed after reset.

module sexpr_byte_tokenizer
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // in_byte[7:0]
    input  logic                        s_tlast,   // at_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sbt_pkg::DATA_W-1:0]  m_tdata,   // out_byte[7:0], int_value[71:8]
    output logic [3:0]                  m_tuser,   // kind[3:0]
    output logic                        m_tlast    // last token of a source byte
);

    localparam int LVL_W = $clog2(FIFO_DEPTH+1);

    // Input register: holds one accepted beat for the lexer pass.
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_end_reg;
    logic                s_accept;

    logic                grp_push;
    sbt_pkg::res_group_t grp;
    logic [LVL_W-1:0]    fifo_level;

    // Take a beat only if the queue can hold the group still in the input
    // register as well as the group of this beat.
    assign s_tready = (32'(fifo_level) + 32'(in_valid_reg)) < FIFO_DEPTH;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= s_accept;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    sbt_lex_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_end   (in_end_reg),
        .grp_push   (grp_push),
        .grp        (grp)
    );

    sbt_result_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (grp_push),
        .grp      (grp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .level    (fifo_level)
    );

    // Never push a group into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        grp_push |-> (32'(fifo_level) < FIFO_DEPTH))
        else $error("result queue overflow");

    // A group not yet finished keeps the output valid.
    a_group_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("result group cut short");

    // Only integer tokens carry a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != sbt_pkg::K_INT) |-> (m_tdata[71:8] == 64'd0))
        else $error("value on non-integer token");

    // The end-of-stream token always closes its group.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == sbt_pkg::K_EOF) |-> m_tlast)
        else $error("eof token not last");

endmodule
